FILE: rtl/core/dhfp_pkg.sv
// Package for the decimal header frame parser.
// Holds the phase encoding, the result word layout, sizing constants and
// the decimal accumulate function. No dependencies.
package dhfp_pkg;

   localparam logic [1:0] COMMAND_DIGITS = 2'd2;
   localparam logic [1:0] SENDER_DIGITS  = 2'd2;
   localparam logic [1:0] LENGTH_DIGITS  = 2'd2;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;
   localparam logic [7:0] START_CHAR_RESET = 8'h24;
   localparam logic [6:0] ACC_MAX = 7'd127;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam int RSP_DATA_W = 32;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_CMD,
      PH_SND,
      PH_LEN,
      PH_PAY
   } phase_type;

   typedef struct packed {
      logic [6:0] command;
      logic [6:0] sender;
      logic [6:0] data_len;
      logic [7:0] data_byte;
      logic       has_byte;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // acc * 10 + digit, saturated to 7 bits
   function automatic logic [6:0] acc_digit(input logic [6:0] acc, input logic [3:0] d);
      logic [10:0] v;
      v = ({4'b0, acc} * 11'd10) + {7'b0, d};
      return (v > {4'b0, ACC_MAX}) ? ACC_MAX : v[6:0];
   endfunction

endpackage

FILE: rtl/core/dhfp_front.sv
// Front end of the frame parser: accepts words, hunts for the start
// character, decodes the header fields and pushes results to the queue.
// Depends on dhfp_pkg.
module dhfp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data,
   input  logic              accept,
   input  logic [7:0]        rx_byte,
   output dhfp_pkg::push_type push
);
   import dhfp_pkg::*;

   phase_type  phase_ff, phase_in;
   logic [1:0] digit_count_ff, digit_count_in;
   logic [6:0] command_ff, command_in;
   logic [6:0] sender_ff, sender_in;
   logic [6:0] length_ff, length_in;
   logic [6:0] left_ff, left_in;
   logic [7:0] start_char_ff;

   logic       is_digit;
   logic [3:0] digit;
   logic [6:0] acc_sel;
   logic [6:0] acc_new;
   logic [1:0] need;
   logic [1:0] count_inc;
   logic       field_done;
   logic [6:0] left_dec;

   assign is_digit  = (rx_byte >= ASCII_ZERO) && (rx_byte <= ASCII_NINE);
   assign digit     = 4'(rx_byte - ASCII_ZERO);
   assign count_inc = digit_count_ff + 2'd1;
   assign field_done = (count_inc == need);
   assign left_dec  = left_ff - 7'd1;
   assign acc_new   = acc_digit(acc_sel, digit);

   always_comb begin
      case (phase_ff)
         PH_CMD: begin
            acc_sel = command_ff;
            need    = COMMAND_DIGITS;
         end
         PH_SND: begin
            acc_sel = sender_ff;
            need    = SENDER_DIGITS;
         end
         default: begin
            acc_sel = length_ff;
            need    = LENGTH_DIGITS;
         end
      endcase
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: if (rx_byte == start_char_ff) phase_in = PH_CMD;
            PH_CMD: begin
               if (!is_digit) phase_in = PH_HUNT;
               else if (field_done) phase_in = PH_SND;
            end
            PH_SND: begin
               if (!is_digit) phase_in = PH_HUNT;
               else if (field_done) phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (!is_digit) phase_in = PH_HUNT;
               else if (field_done) phase_in = (acc_new == 7'd0) ? PH_HUNT : PH_PAY;
            end
            PH_PAY: if (left_dec == 7'd0) phase_in = PH_HUNT;
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // datapath and result push
   always_comb begin
      digit_count_in = digit_count_ff;
      command_in     = command_ff;
      sender_in      = sender_ff;
      length_in      = length_ff;
      left_in        = left_ff;
      push           = '0;
      push.data.command  = command_ff;
      push.data.sender   = sender_ff;
      push.data.data_len = length_ff;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx_byte == start_char_ff) begin
                  digit_count_in = 2'd0;
                  command_in     = 7'd0;
                  sender_in      = 7'd0;
                  length_in      = 7'd0;
                  left_in        = 7'd0;
               end
            end
            PH_CMD, PH_SND, PH_LEN: begin
               if (is_digit) begin
                  digit_count_in = field_done ? 2'd0 : count_inc;
                  if (phase_ff == PH_CMD) command_in = acc_new;
                  else if (phase_ff == PH_SND) sender_in = acc_new;
                  else begin
                     length_in = acc_new;
                     if (field_done) begin
                        left_in = acc_new;
                        if (acc_new == 7'd0) begin
                           push.valid         = 1'b1;
                           push.data.data_len = acc_new;
                           push.data.last     = 1'b1;
                        end
                     end
                  end
               end
            end
            PH_PAY: begin
               left_in             = left_dec;
               push.valid          = 1'b1;
               push.data.data_byte = rx_byte;
               push.data.has_byte  = 1'b1;
               push.data.last      = (left_dec == 7'd0);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HUNT;
         digit_count_ff <= 2'd0;
         command_ff     <= 7'd0;
         sender_ff      <= 7'd0;
         length_ff      <= 7'd0;
         left_ff        <= 7'd0;
         start_char_ff  <= START_CHAR_RESET;
      end else begin
         phase_ff       <= phase_in;
         digit_count_ff <= digit_count_in;
         command_ff     <= command_in;
         sender_ff      <= sender_in;
         length_ff      <= length_in;
         left_ff        <= left_in;
         if (csr_wr_en) start_char_ff <= csr_wr_data;
      end
   end

endmodule

FILE: rtl/core/dhfp_queue.sv
// Short result queue between the parser front end and the output stage.
// Depends on dhfp_pkg.
module dhfp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  dhfp_pkg::push_type         push,
   input  logic                       pop,
   output dhfp_pkg::result_type       head,
   output dhfp_pkg::queue_status_type status
);
   import dhfp_pkg::*;

   result_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push = push.valid && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push.data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/core/dhfp_back.sv
// Output stage: takes results from the queue into the response register
// and packs them onto the rsp stream. Depends on dhfp_pkg.
module dhfp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  dhfp_pkg::result_type              head,
   input  dhfp_pkg::queue_status_type        status,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dhfp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tuser,
   output logic                              rsp_tlast
);
   import dhfp_pkg::*;

   logic       valid_ff, valid_in;
   result_type word_ff;

   assign pop      = !status.empty && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) word_ff <= head;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {3'b0, word_ff.data_byte, word_ff.data_len,
                        word_ff.sender, word_ff.command};
   assign rsp_tuser  = word_ff.has_byte;
   assign rsp_tlast  = word_ff.last;

endmodule

FILE: rtl/core/decimal_header_frame_parser.sv
// Decimal header frame parser, top level.
// Uses dhfp_pkg, dhfp_front, dhfp_queue and dhfp_back.
//
// req stream: one received byte per word. The parser hunts for the start
// character (csr register, reset '$'), then reads two-digit ASCII command,
// sender and length fields, then that many payload bytes. A non-digit in a
// header drops the frame.
// rsp stream: one word per payload byte with the decoded header, or one
// header-only word (tuser low) for a zero-length frame; tlast marks the
// final word of a frame.
// csr: csr_wr_en/csr_wr_data write the start character at a clock edge.
// Throughput: one req word per cycle while the queue is not full. Path: a
// result is written into the queue, then into the output register, before
// it appears on rsp.
// Stall: the four-entry queue absorbs results while rsp_tready is low;
// req_tready drops only when the queue is full or while reset is high.
// Reset (synchronous): back to hunting, queue and output emptied, start
// character '$'.
module decimal_header_frame_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [7:0]                      csr_wr_data,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // [7:0] rx_byte
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [6:0] command, [13:7] sender, [20:14] data_len, [28:21] data_byte
   output logic [dhfp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tuser,  // [0] has_byte
   output logic                            rsp_tlast
);
   import dhfp_pkg::*;

   push_type         push;
   result_type       head;
   queue_status_type status;
   logic             pop;
   logic             accept;

   assign req_tready = !status.full && !reset;
   assign accept     = req_tvalid && req_tready;

   dhfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .rx_byte     (req_tdata),
      .push        (push)
   );

   dhfp_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (pop),
      .head   (head),
      .status (status)
   );

   dhfp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
